/* design/glmf_pkg.sv */
// Shared types and widths for the grid local maximum finder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package glmf_pkg;

    // Fixed field widths of the block's channels.
    localparam int VALUE_W = 32;
    localparam int COORD_W = 3;
    localparam int SIDE_W  = 4;

    // Smallest side the scan supports.
    localparam logic [SIDE_W-1:0] MIN_SIDE = 4'd2;

    // One peak as found by the scan sequencer.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
    } glmf_peak_t;

    // Requests from the scan sequencer to the result queue.
    typedef struct packed {
        logic peak;
        logic end_scan;
    } glmf_push_t;

    // One result as presented on the output channel.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic                      found;
        logic                      last;
    } glmf_result_t;

endpackage

`default_nettype wire

/* design/glmf_grid_ram.sv */
// Grid store: one write port, one read port with registered read data.
// Depends on glmf_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module glmf_grid_ram #(
    parameter int ADDR_W = 6
) (
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [ADDR_W-1:0]                  wr_addr,
    input  wire logic signed [glmf_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                               rd_en,
    input  wire logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [glmf_pkg::VALUE_W-1:0]      rd_data
);
    import glmf_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data is available in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/glmf_result_queue.sv */
// Result queue: holds the latest peak back until the next one or the end of
// the scan shows whether it is the last, and drives the output register.
// Depends on glmf_pkg for the peak, request and result types.
`timescale 1ns / 1ps
`default_nettype none

module glmf_result_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire glmf_pkg::glmf_push_t  push,
    input  wire glmf_pkg::glmf_peak_t  push_data,
    output logic                       push_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output glmf_pkg::glmf_result_t     out_data
);
    import glmf_pkg::*;

    logic         pend_valid_reg, pend_valid_next;
    glmf_peak_t   pend_reg;
    logic         out_valid_reg, out_valid_next;
    glmf_result_t out_reg, out_next;
    logic         slot_free;
    logic         peak_ready;
    logic         peak_acc;
    logic         end_acc;
    logic         out_load;

    // The output register can take a new result when empty or being drained.
    assign slot_free  = !out_valid_reg || out_ready;
    assign peak_ready = !pend_valid_reg || slot_free;
    assign push_ready = push.end_scan ? slot_free : peak_ready;
    assign peak_acc   = push.peak && peak_ready;
    assign end_acc    = push.end_scan && slot_free;
    assign out_load   = (peak_acc && pend_valid_reg) || end_acc;

    // Next output result: a held peak, or the no-peak marker.
    always_comb
    begin
        out_next = out_reg;
        if (end_acc)
        begin
            if (pend_valid_reg)
            begin
                out_next = '{value: pend_reg.value, row: pend_reg.row, col: pend_reg.col,
                             found: 1'b1, last: 1'b1};
            end
            else
            begin
                out_next = '{value: '0, row: '0, col: '0, found: 1'b0, last: 1'b1};
            end
        end
        else if (peak_acc && pend_valid_reg)
        begin
            out_next = '{value: pend_reg.value, row: pend_reg.row, col: pend_reg.col,
                         found: 1'b1, last: 1'b0};
        end
    end

    // Valid flags of the held peak and the output register.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (end_acc)
        begin
            pend_valid_next = 1'b0;
        end
        else if (peak_acc)
        begin
            pend_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (peak_acc)
        begin
            pend_reg <= push_data;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The end of a scan always leaves a final result and nothing held back.
    a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        end_acc |=> (out_valid_reg && out_reg.last && !pend_valid_reg))
        else $error("end of scan did not produce a final result");

    // A peak and the end of the scan are never requested together.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.peak && push.end_scan))
        else $error("peak and end of scan requested in the same cycle");

endmodule

`default_nettype wire

/* design/glmf_scan_seq.sv */
// Scan sequencer: walks the grid in row-major order, reads each cell and its
// neighbors through the single store read port and compares them in one
// shared signed comparator. Depends on glmf_pkg for types and widths.
`timescale 1ns / 1ps
`default_nettype none

module glmf_scan_seq #(
    parameter int ADDR_W = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [glmf_pkg::SIDE_W-1:0]        side,
    output logic                                    idle,
    output logic                                    rd_en,
    output logic [ADDR_W-1:0]                       rd_addr,
    input  wire logic signed [glmf_pkg::VALUE_W-1:0] rd_data,
    output glmf_pkg::glmf_push_t                    push,
    output glmf_pkg::glmf_peak_t                    push_data,
    input  wire logic                               push_ready
);
    import glmf_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    // Kind of the read whose data arrives in the current cycle.
    localparam logic [1:0] TAG_NONE   = 2'd0;
    localparam logic [1:0] TAG_CENTER = 2'd1;
    localparam logic [1:0] TAG_NEIGH  = 2'd2;

    // Read steps per cell: the center, then the nine places of the 3x3 window.
    localparam logic [3:0] LAST_STEP = 4'd9;

    localparam int FULL_W = COORD_W + SIDE_W;

    logic [2:0]                state_reg, state_next;
    logic [3:0]                step_reg, step_next;
    logic [COORD_W-1:0]        row_reg, row_next;
    logic [COORD_W-1:0]        col_reg, col_next;
    logic [SIDE_W-1:0]         side_reg;
    logic [1:0]                tag_reg, tag_next;
    logic                      ok_reg, ok_next;
    logic signed [VALUE_W-1:0] center_reg;
    logic [1:0]                dr_off;
    logic [1:0]                dc_off;
    logic [SIDE_W-1:0]         nb_row;
    logic [SIDE_W-1:0]         nb_col;
    logic                      nb_valid;
    logic [FULL_W-1:0]         addr_full;
    logic                      greater;
    logic                      advance;
    logic                      last_col;
    logic                      last_row;

    // Window offset for each read step; step zero and the middle are the center.
    always_comb
    begin
        case (step_reg)
            4'd1:    begin dr_off = 2'd0; dc_off = 2'd0; end
            4'd2:    begin dr_off = 2'd0; dc_off = 2'd1; end
            4'd3:    begin dr_off = 2'd0; dc_off = 2'd2; end
            4'd4:    begin dr_off = 2'd1; dc_off = 2'd0; end
            4'd6:    begin dr_off = 2'd1; dc_off = 2'd2; end
            4'd7:    begin dr_off = 2'd2; dc_off = 2'd0; end
            4'd8:    begin dr_off = 2'd2; dc_off = 2'd1; end
            4'd9:    begin dr_off = 2'd2; dc_off = 2'd2; end
            default: begin dr_off = 2'd1; dc_off = 2'd1; end
        endcase
    end

    // Neighbor coordinates; stepping off the top or left wraps far out of range.
    assign nb_row    = {1'b0, row_reg} + SIDE_W'(dr_off) - SIDE_W'(1);
    assign nb_col    = {1'b0, col_reg} + SIDE_W'(dc_off) - SIDE_W'(1);
    assign nb_valid  = (nb_row < side_reg) && (nb_col < side_reg)
                       && !(dr_off == 2'd1 && dc_off == 2'd1);
    assign addr_full = FULL_W'(nb_row[COORD_W-1:0] * side_reg)
                       + FULL_W'(nb_col[COORD_W-1:0]);

    // Store read request: the center on step zero, existing neighbors after it.
    assign rd_en   = (state_reg == S_ISSUE) && (step_reg == 4'd0 || nb_valid);
    assign rd_addr = addr_full[ADDR_W-1:0];

    // The shared comparator.
    assign greater = center_reg > rd_data;

    assign last_col = ({1'b0, col_reg} == side_reg - SIDE_W'(1));
    assign last_row = ({1'b0, row_reg} == side_reg - SIDE_W'(1));
    assign advance  = (state_reg == S_DECIDE) && (!ok_reg || push_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ok_next    = ok_reg;
        tag_next   = TAG_NONE;

        if (rd_en)
        begin
            tag_next = (step_reg == 4'd0) ? TAG_CENTER : TAG_NEIGH;
        end
        if (tag_reg == TAG_NEIGH && !greater)
        begin
            ok_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ISSUE;
                    step_next  = 4'd0;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            S_ISSUE:
            begin
                if (step_reg == 4'd0)
                begin
                    ok_next = 1'b1;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (advance)
                begin
                    step_next = 4'd0;
                    if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            row_next   = row_reg + COORD_W'(1);
                            state_next = S_ISSUE;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + COORD_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINAL:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            tag_reg   <= TAG_NONE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            tag_reg   <= tag_next;
            ok_reg    <= ok_next;
        end
    end

    // Side of the grid under scan and the center value.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            side_reg <= side;
        end
        if (tag_reg == TAG_CENTER)
        begin
            center_reg <= rd_data;
        end
    end

    assign idle           = (state_reg == S_IDLE);
    assign push.peak      = (state_reg == S_DECIDE) && ok_reg;
    assign push.end_scan  = (state_reg == S_FINAL);
    assign push_data      = '{value: center_reg, row: row_reg, col: col_reg};

    // A new scan is started only while the previous one is finished.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("scan started while busy");

    // Every read of a cell's window has landed before the cell is judged.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (tag_reg == TAG_NONE))
        else $error("store read still in flight at decision");

endmodule

`default_nettype wire

/* design/grid_local_maximum_finder_unit.sv */
// Grid local maximum finder: loads a square grid one value a request, then
// reports each cell strictly greater than all of its existing 8-neighbors.
// Loading accepts one cell per cycle while no scan runs; the scan of each cell uses
// ten read steps on the single store read port (at most nine used), a drain step
// and a decision, which waits while the result queue is not ready; a closing step
// follows the last cell. Input is not ready while a scan runs.
// Reset sets the side register to 3 and the load position to 0; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module grid_local_maximum_finder_unit #(
    parameter int MAX_SIDE = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [glmf_pkg::SIDE_W-1:0]         cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [glmf_pkg::VALUE_W-1:0] cell_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [glmf_pkg::VALUE_W-1:0]      peak_value,
    output logic [glmf_pkg::COORD_W-1:0]             peak_row,
    output logic [glmf_pkg::COORD_W-1:0]             peak_col,
    output logic                                     found,
    output logic                                     last_result
);
    import glmf_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd3;
    localparam logic [SIDE_W-1:0] SIDE_TOP   = SIDE_W'(MAX_SIDE);

    logic [SIDE_W-1:0]    side_cfg_reg, side_cfg_next;
    logic [CNT_W-1:0]     load_pos_reg, load_pos_next;
    logic [SIDE_W-1:0]    side_eff;
    logic [CNT_W-1:0]     cells;
    logic                 cfg_acc;
    logic                 in_acc;
    logic                 last_cell;
    logic                 scan_idle;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    glmf_push_t           push;
    glmf_peak_t           push_data;
    logic                 push_ready;
    glmf_result_t         out_data;

    // Side in use, held within the supported range.
    always_comb
    begin
        if (side_cfg_reg < MIN_SIDE)
        begin
            side_eff = MIN_SIDE;
        end
        else if (side_cfg_reg > SIDE_TOP)
        begin
            side_eff = SIDE_TOP;
        end
        else
        begin
            side_eff = side_cfg_reg;
        end
    end

    assign cells     = CNT_W'(side_eff * side_eff);
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_ready  = scan_idle;
    assign in_acc    = in_valid && in_ready;
    assign last_cell = (load_pos_reg + CNT_W'(1) == cells);

    // Side register and load position; a side write restarts loading.
    always_comb
    begin
        side_cfg_next = side_cfg_reg;
        load_pos_next = load_pos_reg;
        if (cfg_acc)
        begin
            side_cfg_next = cfg_data;
            load_pos_next = '0;
        end
        else if (in_acc)
        begin
            load_pos_next = last_cell ? '0 : load_pos_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= SIDE_RESET;
            load_pos_reg <= '0;
        end
        else
        begin
            side_cfg_reg <= side_cfg_next;
            load_pos_reg <= load_pos_next;
        end
    end

    glmf_grid_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (load_pos_reg[ADDR_W-1:0]),
        .wr_data (cell_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    glmf_scan_seq #(
        .ADDR_W (ADDR_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_acc && last_cell),
        .side       (side_eff),
        .idle       (scan_idle),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    glmf_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign peak_value  = out_data.value;
    assign peak_row    = out_data.row;
    assign peak_col    = out_data.col;
    assign found       = out_data.found;
    assign last_result = out_data.last;

    // The no-peak result is always the only and final one of its scan.
    a_nopeak_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> last_result)
        else $error("no-peak result not marked as last");

    // The load position never runs past the grid in use.
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_pos_reg < cells)
        else $error("load position beyond grid");

endmodule

`default_nettype wire
